// ===== design/swes_pkg.sv =====
package swes_pkg;

   localparam int MAX_BUCKETS = 64;
   localparam int SLOT_W      = $clog2(MAX_BUCKETS);
   localparam int TOTAL_W     = $clog2(MAX_BUCKETS + 1);
   localparam int TIME_W      = 32;
   localparam int SUM_W       = 32;
   localparam int CNT_W       = 16;
   localparam int DEPTH_W     = 16;
   localparam int WIN_W       = 16;
   localparam int CMD_W       = 2;
   localparam int ENTRY_W     = TIME_W + SUM_W;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD         = 2'd0,
      CMD_READ_EXPIRE = 2'd1,
      CMD_READ_WINDOW = 2'd2,
      CMD_FLUSH       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RD_NEWEST,
      RD_OLDEST,
      RD_INDEX
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       add_write;
      logic       total_clr;
      logic       total_dec;
      logic       scan_clr;
      logic       sum_acc;
      logic       res_load;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    total_zero;
      logic    expire_hit;
      logic    stop_hit;
      logic    idx_done;
      logic    rsp_busy;
   } dp_sts_type;

endpackage

// ===== design/swes_req_if.sv =====
interface swes_req_if
   import swes_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [TIME_W-1:0]  timestamp;
   logic [CNT_W-1:0]   count;
   logic [DEPTH_W-1:0] read_depth;

   modport source (output valid, command, timestamp, count, read_depth, input ready);
   modport sink (input valid, command, timestamp, count, read_depth, output ready);
endinterface

// ===== design/swes_rsp_if.sv =====
interface swes_rsp_if
   import swes_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] window_sum;

   modport source (output valid, window_sum, input ready);
   modport sink (input valid, window_sum, output ready);
endinterface

// ===== design/swes_ram.sv =====
module swes_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/swes_datapath.sv =====
module swes_datapath
   import swes_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        ctl,
   output dp_sts_type         sts,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [TIME_W-1:0]  req_timestamp,
   input  logic [CNT_W-1:0]   req_count,
   input  logic [DEPTH_W-1:0] req_read_depth,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SUM_W-1:0]   rsp_window_sum,
   input  logic               csr_write_enable,
   input  logic [WIN_W-1:0]   csr_write_data
);

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0]  newest,
                                                    input logic [TOTAL_W-1:0] k);
      logic [TOTAL_W:0] n;
      logic [TOTAL_W:0] d;
      n = (TOTAL_W+1)'(newest);
      d = (TOTAL_W+1)'(k);
      if (n >= d) begin
         slot_back = SLOT_W'(n - d);
      end else begin
         slot_back = SLOT_W'(n + (TOTAL_W+1)'(MAX_BUCKETS) - d);
      end
   endfunction

   cmd_type            cmd_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [WIN_W-1:0]   win_ff;
   logic [SLOT_W-1:0]  newest_ff, newest_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   res_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SLOT_W-1:0]  rd_addr;
   logic [SLOT_W-1:0]  newest_next;
   logic [ENTRY_W-1:0] rd_data;
   logic [TIME_W-1:0]  rd_time;
   logic [SUM_W-1:0]   rd_count;
   logic               merge;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   assign rd_time  = rd_data[ENTRY_W-1:SUM_W];
   assign rd_count = rd_data[SUM_W-1:0];

   assign newest_next = (newest_ff == SLOT_W'(MAX_BUCKETS - 1)) ? '0 : newest_ff + 1'b1;

   always_comb begin
      case (ctl.rd_sel)
         RD_NEWEST: rd_addr = newest_ff;
         RD_OLDEST: rd_addr = slot_back(newest_ff, total_ff - 1'b1);
         RD_INDEX:  rd_addr = slot_back(newest_ff, idx_ff);
         default:   rd_addr = newest_ff;
      endcase
   end

   assign merge   = (total_ff != '0) && (rd_time == now_ff);
   assign wr_en   = ctl.add_write;
   assign wr_addr = merge ? newest_ff : newest_next;
   assign wr_data = merge ? {rd_time, rd_count + SUM_W'(cnt_ff)}
                          : {now_ff, SUM_W'(cnt_ff)};

   swes_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      newest_in = newest_ff;
      total_in  = total_ff;
      if (ctl.add_write && !merge) begin
         newest_in = newest_next;
         if (total_ff != TOTAL_W'(MAX_BUCKETS)) begin
            total_in = total_ff + 1'b1;
         end
      end
      if (ctl.total_dec) begin
         total_in = total_ff - 1'b1;
      end
      if (ctl.total_clr) begin
         total_in = '0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      if (ctl.scan_clr) begin
         idx_in = '0;
         sum_in = '0;
      end else if (ctl.sum_acc) begin
         idx_in = idx_ff + 1'b1;
         sum_in = sum_ff + rd_count;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_RESET;
         newest_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            win_ff <= csr_write_data;
         end
         newest_ff    <= newest_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= cmd_type'(req_command);
         now_ff   <= req_timestamp;
         cnt_ff   <= req_count;
         depth_ff <= req_read_depth;
      end
      if (ctl.res_load) begin
         res_ff <= sum_ff;
      end
      idx_ff <= idx_in;
      sum_ff <= sum_in;
   end

   assign sts.cmd        = cmd_ff;
   assign sts.total_zero = (total_ff == '0);
   assign sts.expire_hit = ({1'b0, rd_time} + (TIME_W+1)'(win_ff)) <= {1'b0, now_ff};
   assign sts.stop_hit   = ({1'b0, rd_time} + (TIME_W+1)'(depth_ff)) < {1'b0, now_ff};
   assign sts.idx_done   = (idx_ff == total_ff);
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = res_ff;

endmodule

// ===== design/swes_controller.sv =====
module swes_controller
   import swes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_sts_type  sts,
   output ctl_cmd_type ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_WR,
      S_EXP_RD,
      S_EXP_CHK,
      S_SUM_RD,
      S_SUM_CHK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ctl      = '0;
      ctl.rd_sel = RD_NEWEST;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.scan_clr = 1'b1;
            case (sts.cmd)
               CMD_ADD: begin
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = RD_NEWEST;
                  state_in   = S_ADD_WR;
               end
               CMD_READ_EXPIRE: state_in = S_EXP_RD;
               CMD_READ_WINDOW: state_in = S_SUM_RD;
               CMD_FLUSH: begin
                  ctl.total_clr = 1'b1;
                  state_in      = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADD_WR: begin
            ctl.add_write = 1'b1;
            state_in      = S_EXP_RD;
         end
         S_EXP_RD: begin
            if (sts.total_zero) begin
               state_in = (sts.cmd == CMD_ADD) ? S_IDLE : S_SUM_RD;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_OLDEST;
               state_in   = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (sts.expire_hit) begin
               ctl.total_dec = 1'b1;
               state_in      = S_EXP_RD;
            end else begin
               state_in = (sts.cmd == CMD_ADD) ? S_IDLE : S_SUM_RD;
            end
         end
         S_SUM_RD: begin
            if (sts.idx_done) begin
               state_in = S_DONE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_INDEX;
               state_in   = S_SUM_CHK;
            end
         end
         S_SUM_CHK: begin
            if (sts.cmd == CMD_READ_WINDOW && sts.stop_hit) begin
               state_in = S_DONE;
            end else begin
               ctl.sum_acc = 1'b1;
               state_in    = S_SUM_RD;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               ctl.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sliding_window_event_sum.sv =====
// Channel  Port group    Dir  Payload
// req      req (sink)    in   command, timestamp, count, read_depth
// rsp      rsp (source)  out  window_sum
// csr      csr_write_*   in   window_seconds
//
// One item at a time, taken on req only in idle; reset empties the list, window_seconds = 10.
// Add: read the newest bucket, write or merge it, then expire old buckets; flush: clear
// the list; read and expire: expire, then sum all buckets; read window: sum, stopping
// early at the first bucket older than timestamp minus read_depth. Each step is one
// registered RAM read and one check. A result waits in the output register while the
// next item runs; a read that finishes before rsp is taken holds.
module sliding_window_event_sum
   import swes_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   swes_req_if.sink         req,
   swes_rsp_if.source       rsp,
   input  logic             csr_write_enable,
   input  logic [WIN_W-1:0] csr_write_data
);

   ctl_cmd_type ctl;
   dp_sts_type  sts;
   logic        req_ready;

   assign req.ready = req_ready;

   swes_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   swes_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req.command),
      .req_timestamp    (req.timestamp),
      .req_count        (req.count),
      .req_read_depth   (req.read_depth),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_window_sum   (rsp.window_sum),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.total_dec |-> !sts.total_zero)
      else $error("bucket count decremented while empty");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.res_load |-> !sts.rsp_busy)
      else $error("result loaded over a pending response");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req_ready) |=> !req_ready)
      else $error("request taken while previous item still in progress");
`endif

endmodule

// ===== test/tb_sliding_window_event_sum.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_event_sum;
   import swes_pkg::*;

   localparam int DRAIN_CYCLES = 4 * MAX_BUCKETS + 40;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      cmd_type            command;
      logic [TIME_W-1:0]  timestamp;
      logic [CNT_W-1:0]   count;
      logic [DEPTH_W-1:0] read_depth;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [WIN_W-1:0] csr_write_data = '0;

   swes_req_if req_ch();
   swes_rsp_if rsp_ch();

   sliding_window_event_sum u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_item_type     req_backlog[$];
   logic [SUM_W-1:0] window_sum_expect[$];
   int               fail_count = 0;
   int               idle_pct = 29;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   logic             req_taken = 1'b0;

   // bucket list as the block should hold it
   logic [TIME_W-1:0] slot_time[MAX_BUCKETS];
   logic [SUM_W-1:0]  slot_count[MAX_BUCKETS];
   int                newest_idx;
   int                held;
   logic [WIN_W-1:0]  window_cfg;

   function automatic int slot_at(input int k);
      return (newest_idx + MAX_BUCKETS - k) % MAX_BUCKETS;
   endfunction

   function automatic void age_out(input logic [TIME_W-1:0] now);
      longint limit;
      limit = longint'(now) - longint'(window_cfg);
      while (held > 0 && longint'(slot_time[slot_at(held - 1)]) <= limit)
         held = held - 1;
   endfunction

   function automatic void track_command(input req_item_type it);
      logic [SUM_W-1:0] total;
      longint           limit;
      int               k;
      total = '0;
      case (it.command)
         CMD_ADD: begin
            if (held > 0 && slot_time[newest_idx] == it.timestamp) begin
               slot_count[newest_idx] = slot_count[newest_idx] + SUM_W'(it.count);
            end else begin
               newest_idx = (newest_idx + 1) % MAX_BUCKETS;
               slot_time[newest_idx]  = it.timestamp;
               slot_count[newest_idx] = SUM_W'(it.count);
               if (held < MAX_BUCKETS) held = held + 1;
            end
            age_out(it.timestamp);
         end
         CMD_FLUSH: begin
            held = 0;
         end
         CMD_READ_EXPIRE: begin
            age_out(it.timestamp);
            for (k = 0; k < held; k++) total = total + slot_count[slot_at(k)];
            window_sum_expect.push_back(total);
         end
         default: begin
            limit = longint'(it.timestamp) - longint'(it.read_depth);
            for (k = 0; k < held; k++) begin
               if (longint'(slot_time[slot_at(k)]) < limit) break;
               total = total + slot_count[slot_at(k)];
            end
            window_sum_expect.push_back(total);
         end
      endcase
   endfunction

   // monitor: request transfers feed the tracker, result transfers are checked
   always @(posedge clock) begin
      req_item_type     it;
      logic [SUM_W-1:0] want;
      req_taken = 1'b0;
      if (reset) begin
         newest_idx = 0;
         held       = 0;
         window_cfg = WINDOW_RESET;
      end else begin
         if (csr_write_enable) window_cfg = csr_write_data;
         if (req_ch.valid && req_ch.ready) begin
            req_taken     = 1'b1;
            it.command    = cmd_type'(req_ch.command);
            it.timestamp  = req_ch.timestamp;
            it.count      = req_ch.count;
            it.read_depth = req_ch.read_depth;
            track_command(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (window_sum_expect.size() == 0) begin
               $error("window_sum: unexpected transfer, actual %0h", rsp_ch.window_sum);
               fail_count++;
            end else begin
               want = window_sum_expect.pop_front();
               if (rsp_ch.window_sum !== want) begin
                  $error("window_sum: expected %0h actual %0h", want, rsp_ch.window_sum);
                  fail_count++;
               end
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      req_item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            it = req_backlog.pop_front();
            req_ch.command    <= it.command;
            req_ch.timestamp  <= it.timestamp;
            req_ch.count      <= it.count;
            req_ch.read_depth <= it.read_depth;
            req_ch.valid      <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic queue_cmd(input cmd_type c, input logic [TIME_W-1:0] ts,
                            input logic [CNT_W-1:0] cnt, input logic [DEPTH_W-1:0] depth);
      req_item_type it;
      it.command    = c;
      it.timestamp  = ts;
      it.count      = cnt;
      it.read_depth = depth;
      req_backlog.push_back(it);
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_ch.valid || window_sum_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int n, input int win);
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] ts;
      logic [DEPTH_W-1:0] depth;
      cmd_type c;
      int roll;
      case ($urandom_range(2))
         0:       now = '0;
         1:       now = $urandom;
         default: now = 32'hFFFF_FF80;
      endcase
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            ts = $urandom;
         end else begin
            if (roll < 14) now = now + $urandom_range(0, 2 * win);
            else now = now + $urandom_range(0, 3);
            ts = now;
         end
         roll = $urandom_range(99);
         if (roll < 50) c = CMD_ADD;
         else if (roll < 72) c = CMD_READ_EXPIRE;
         else if (roll < 96) c = CMD_READ_WINDOW;
         else c = CMD_FLUSH;
         if ($urandom_range(3) == 0) depth = DEPTH_W'($urandom_range(0, 65535));
         else depth = DEPTH_W'($urandom_range(0, 12));
         queue_cmd(c, ts, CNT_W'($urandom_range(0, 65535)), depth);
      end
   endtask

   initial begin
      logic [WIN_W-1:0] win_list[6];
      int i;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_ADD;
      req_ch.timestamp  = '0;
      req_ch.count      = '0;
      req_ch.read_depth = '0;
      rsp_ch.ready      = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_window(16'd10);
      queue_cmd(CMD_READ_EXPIRE, 32'd0, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd0, 16'd0, 16'd0);
      queue_cmd(CMD_ADD, 32'd0, 16'd0, 16'd0);
      queue_cmd(CMD_ADD, 32'd0, 16'hFFFF, 16'd0);
      queue_cmd(CMD_ADD, 32'd5, 16'd1, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd5, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd3, 16'd0, 16'hFFFF);
      queue_cmd(CMD_READ_EXPIRE, 32'd5, 16'd0, 16'd0);
      queue_cmd(CMD_ADD, 32'd20, 16'd7, 16'd0);
      queue_cmd(CMD_READ_EXPIRE, 32'd20, 16'd0, 16'd0);
      queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(CMD_READ_WINDOW, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(CMD_READ_EXPIRE, 32'hFFFF_FFFF, 16'd0, 16'd0);
      queue_cmd(CMD_FLUSH, 32'hAAAA_AAAA, 16'hAAAA, 16'hAAAA);
      queue_cmd(CMD_READ_EXPIRE, 32'h5555_5555, 16'h5555, 16'h5555);
      queue_cmd(CMD_ADD, 32'h8000_0000, 16'hAAAA, 16'd0);
      queue_cmd(CMD_ADD, 32'h8000_0001, 16'h5555, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'h8000_0001, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'h8000_0001, 16'd0, 16'd1);
      queue_cmd(CMD_READ_EXPIRE, 32'h8000_000A, 16'd0, 16'd0);

      // zero window: an add expires even its own bucket
      write_window(16'd0);
      queue_cmd(CMD_ADD, 32'd50, 16'd3, 16'd0);
      queue_cmd(CMD_READ_EXPIRE, 32'd50, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd50, 16'd0, 16'd0);

      // overfill the store
      write_window(16'hFFFF);
      queue_cmd(CMD_FLUSH, 32'd0, 16'd0, 16'd0);
      for (i = 0; i < MAX_BUCKETS + 6; i++)
         queue_cmd(CMD_ADD, 32'd100 + i, CNT_W'($urandom_range(0, 65535)), 16'd0);
      queue_cmd(CMD_READ_EXPIRE, 32'd170, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd169, 16'd0, 16'd10);

      win_list[0] = 16'd1;
      win_list[1] = 16'd3;
      win_list[2] = 16'd10;
      win_list[3] = 16'd40;
      win_list[4] = 16'hFFFF;
      win_list[5] = WIN_W'($urandom_range(2, 300));
      for (i = 0; i < 6; i++) begin
         write_window(win_list[i]);
         idle_pct = (i == 1) ? 0 : 29;
         if (i == 2) hold_requests++;
         run_random(55, win_list[i]);
      end

      // merged counts in one bucket
      write_window(16'd100);
      idle_pct = 0;
      queue_cmd(CMD_FLUSH, 32'd0, 16'd0, 16'd0);
      repeat (8) queue_cmd(CMD_ADD, 32'd1000, 16'hFFFF, 16'd0);
      queue_cmd(CMD_ADD, 32'd1001, 16'hFFFF, 16'd0);
      queue_cmd(CMD_READ_EXPIRE, 32'd1001, 16'd0, 16'd0);
      queue_cmd(CMD_ADD, 32'd1001, 16'hFFFF, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd1001, 16'd0, 16'd1);
      repeat (8) queue_cmd(CMD_ADD, 32'd1001, 16'hFFFF, 16'd0);
      queue_cmd(CMD_READ_EXPIRE, 32'd1001, 16'd0, 16'd0);
      queue_cmd(CMD_READ_WINDOW, 32'd1001, 16'd0, 16'd0);
      settle();

      if (fail_count == 0)
         $display("sliding_window_event_sum regression: pass");
      else
         $display("sliding_window_event_sum regression: fail");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("sliding_window_event_sum regression: fail");
      $finish;
   end

endmodule
